FILE: sv/fmgn_pkg.sv
// Shared types and constants of the frame min/max gray normalizer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package fmgn_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int GRAY_W     = 8;
	localparam int IDX_W      = 8;
	localparam int DIM_W      = 9;
	localparam int FS_W       = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// |v| or v-min, one bit over the sample width
	localparam int MAG_W      = SAMPLE_W + 1;
	// magnitude times 255
	localparam int GRAY_NUM_W = MAG_W + GRAY_W;
	// divisor: span of the frame or the full scale
	localparam int DEN_W      = SAMPLE_W;

	localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH      = 2'd0,
		REG_HEIGHT     = 2'd1,
		REG_DIFF_MODE  = 2'd2,
		REG_FULL_SCALE = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PRE,
		ST_GDIV,
		ST_OUT,
		ST_CSTART,
		ST_CDIV
	} state_t;

	// divider command: start a run, long run for pixel coordinates
	typedef struct packed {
		logic start;
		logic wide;
	} div_ctl_t;

endpackage

`default_nettype wire

FILE: sv/frame_minmax_gray_normalizer.sv
// Top level of the frame min/max gray normalizer: control, counters, min/max tracking.
// Depends on fmgn_pkg, fmgn_store (frame memory) and fmgn_div (shared divider).
`default_nettype none

// Channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// command  | cmd_valid / cmd_stall| command, sample
// pixel    | pix_valid / pix_stall| gray, column, out_row, last_pixel, ready_res
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Loads stream at one item per clock into the frame memory while the control is idle.
// A fetch passes through memory read, setup, 8 steps of the shared divider and output.
// A fetch clipped at white skips the divider; a fetch before the frame is complete
// skips the memory read as well. A config write stalls items while the divider
// rebuilds the pixel coordinates.
// The output register lets the next item in while a result is stalled.
// Reset is asynchronous; the frame memory is not cleared.

module frame_minmax_gray_normalizer import fmgn_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command channel
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire logic                  command,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	// pixel channel
	output logic                       pix_valid,
	input  wire logic                  pix_stall,
	output logic      [GRAY_W-1:0]     gray,
	output logic      [IDX_W-1:0]      column,
	output logic      [IDX_W-1:0]      out_row,
	output logic                       last_pixel,
	output logic                       ready_res,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = ADDR_W + 1;
	localparam int DIV_NUM_W = (CNT_W > GRAY_NUM_W) ? CNT_W : GRAY_NUM_W;
	localparam int DIV_Q_W   = (CNT_W > GRAY_W) ? CNT_W : GRAY_W;
	// clamp limits as seen by a 9-bit size register
	localparam int DIM_MAX   = (1 << DIM_W) - 1;
	localparam int CLAMP_W   = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
	localparam int CLAMP_H   = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
	localparam int RST_DIM   = 256;
	localparam int RST_W     = (CLAMP_W < RST_DIM) ? CLAMP_W : RST_DIM;
	localparam int RST_H     = (CLAMP_H < RST_DIM) ? CLAMP_H : RST_DIM;
	localparam int RST_TOTAL = RST_W * RST_H;
	localparam int RST_FS    = 50;

	// ---------------------------------------------------------------- registers
	state_t state_q, state_d;

	logic [DIM_W-1:0] width_q, height_q;
	logic             diff_mode_q;
	logic [FS_W-1:0]  full_scale_q;

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] load_cnt_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] base_q;      // store index of the first pixel of the current row
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             complete_q;

	logic signed [SAMPLE_W-1:0] min_q, max_q;

	// fetch in flight
	logic [MAG_W-1:0]  mag_q;
	logic [DEN_W-1:0]  den_q;
	logic [GRAY_W-1:0] pend_gray_q;
	logic [IDX_W-1:0]  pend_col_q;
	logic [IDX_W-1:0]  pend_row_q;
	logic              pend_last_q;
	logic              pend_rdy_q;

	// output register
	logic              pix_valid_q;
	logic [GRAY_W-1:0] gray_q;
	logic [IDX_W-1:0]  column_q;
	logic [IDX_W-1:0]  out_row_q;
	logic              last_q;
	logic              rdy_q;

	// ---------------------------------------------------------------- handshakes
	logic cmd_acc, cfg_acc, out_free;
	logic is_load, is_fetch;

	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign out_free = !pix_valid_q || !pix_stall;
	assign is_load  = cmd_acc && (command == CMD_LOAD);
	assign is_fetch = cmd_acc && (command == CMD_FETCH);

	// ---------------------------------------------------------------- frame size
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [2*DIM_W-1:0] area;
	logic [CNT_W-1:0]   w_ext;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (int'(width_q) > CLAMP_W) begin
			w_eff = DIM_W'(CLAMP_W);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (int'(height_q) > CLAMP_H) begin
			h_eff = DIM_W'(CLAMP_H);
		end else begin
			h_eff = height_q;
		end
	end

	assign area  = w_eff * h_eff;
	assign w_ext = CNT_W'(w_eff);

	// ---------------------------------------------------------------- load path
	logic [CNT_W-1:0] lc_e, lc_inc;
	logic             load_done;

	assign lc_e      = complete_q ? '0 : load_cnt_q;
	assign lc_inc    = lc_e + 1'b1;
	assign load_done = lc_inc >= total_q;

	// ---------------------------------------------------------------- fetch path
	// A read count at or past the pixel count (after a shrink) restarts at 0.
	logic             wrap;
	logic [CNT_W-1:0] rc_e, rc_inc, base_e, src;
	logic [DIM_W-1:0] col_e, row_e;
	logic [CNT_W-1:0] rc_n, base_n;
	logic [DIM_W-1:0] col_n, row_n;

	assign wrap   = rd_cnt_q >= total_q;
	assign rc_e   = wrap ? '0 : rd_cnt_q;
	assign col_e  = wrap ? '0 : col_q;
	assign row_e  = wrap ? '0 : row_q;
	assign base_e = wrap ? (total_q - w_ext) : base_q;
	assign src    = base_e + CNT_W'(col_e);
	assign rc_inc = rc_e + 1'b1;

	always_comb begin
		if (rc_inc >= total_q) begin
			rc_n   = '0;
			col_n  = '0;
			row_n  = '0;
			base_n = total_q - w_ext;
		end else if (col_e == w_eff - 1'b1) begin
			rc_n   = rc_inc;
			col_n  = '0;
			row_n  = row_e + 1'b1;
			base_n = base_e - w_ext;
		end else begin
			rc_n   = rc_inc;
			col_n  = col_e + 1'b1;
			row_n  = row_e;
			base_n = base_e;
		end
	end

	// ---------------------------------------------------------------- frame memory
	logic [SAMPLE_W-1:0] rd_data;
	logic                rd_en;

	assign rd_en = (state_q == ST_IDLE) && is_fetch && complete_q;

	fmgn_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (is_load),
		.wr_addr (lc_e[ADDR_W-1:0]),
		.wr_data (sample),
		.rd_en   (rd_en),
		.rd_addr (src[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------- gray operands
	// normal: v - min clipped at 0 over span (0 counts as 1)
	// difference: |v| over full scale (0 counts as 1)
	logic [MAG_W-1:0] v_ext, d_ext, abs_v, pos_d;
	logic [MAG_W-1:0] span_ext;
	logic [DEN_W-1:0] span_den, fs_den;

	assign v_ext    = {rd_data[SAMPLE_W-1], rd_data};
	assign d_ext    = v_ext - {min_q[SAMPLE_W-1], min_q};
	assign pos_d    = (d_ext[MAG_W-1] || d_ext == '0) ? '0 : d_ext;
	assign abs_v    = v_ext[MAG_W-1] ? (~v_ext + 1'b1) : v_ext;
	assign span_ext = {max_q[SAMPLE_W-1], max_q} - {min_q[SAMPLE_W-1], min_q};
	assign span_den = (span_ext[DEN_W-1:0] == '0) ? DEN_W'(1) : span_ext[DEN_W-1:0];
	assign fs_den   = (full_scale_q == '0) ? DEN_W'(1) : DEN_W'(full_scale_q);

	// n*255 and the clip-to-white test (quotient would reach 256)
	logic [GRAY_NUM_W-1:0] big_n;
	logic                  sat;

	assign big_n = (GRAY_NUM_W'(mag_q) << GRAY_W) - GRAY_NUM_W'(mag_q);
	assign sat   = big_n >= GRAY_NUM_W'({den_q, {GRAY_W{1'b0}}});

	// ---------------------------------------------------------------- shared divider
	div_ctl_t             div_ctl;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DEN_W-1:0]     div_den;
	logic [DIV_Q_W-1:0]   div_quo;
	logic [DEN_W-1:0]     div_rem;
	logic                 div_done;

	// coordinate run: read count / width; pixel run: n*255 / divisor
	assign div_num = (state_q == ST_CSTART) ? DIV_NUM_W'(rd_cnt_q) : DIV_NUM_W'(big_n);
	assign div_den = (state_q == ST_CSTART) ? DEN_W'(w_eff) : den_q;

	fmgn_div #(
		.NUM_W (DIV_NUM_W),
		.Q_W   (DIV_Q_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	// ---------------------------------------------------------------- state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_fetch) begin
					state_d = complete_q ? ST_READ : ST_OUT;
				end else if (cfg_acc) begin
					state_d = ST_CSTART;
				end
			end
			ST_READ:   state_d = ST_PRE;
			ST_PRE:    state_d = sat ? ST_OUT : ST_GDIV;
			ST_GDIV:   state_d = div_done ? ST_OUT : ST_GDIV;
			ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
			ST_CSTART: state_d = ST_CDIV;
			ST_CDIV:   state_d = div_done ? ST_IDLE : ST_CDIV;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall     = 1'b1;
		cfg_ready     = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.wide  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				// an item waiting at the command port goes first
				cfg_ready = !cmd_valid;
			end
			ST_PRE: begin
				div_ctl.start = !sat;
			end
			ST_CSTART: begin
				div_ctl.start = 1'b1;
				div_ctl.wide  = 1'b1;
			end
			ST_READ, ST_GDIV, ST_OUT, ST_CDIV: begin
				cmd_stall = 1'b1;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			width_q      <= DIM_W'(RST_DIM);
			height_q     <= DIM_W'(RST_DIM);
			diff_mode_q  <= 1'b0;
			full_scale_q <= FS_W'(RST_FS);
			total_q      <= CNT_W'(RST_TOTAL);
			load_cnt_q   <= '0;
			rd_cnt_q     <= '0;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= CNT_W'(RST_TOTAL - RST_W);
			complete_q   <= 1'b0;
			min_q        <= '0;
			max_q        <= '0;
			pix_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= CNT_W'(area);

			if (cfg_acc) begin
				unique case (cfg_index)
					REG_WIDTH:      width_q      <= cfg_data[DIM_W-1:0];
					REG_HEIGHT:     height_q     <= cfg_data[DIM_W-1:0];
					REG_DIFF_MODE:  diff_mode_q  <= cfg_data[0];
					REG_FULL_SCALE: full_scale_q <= cfg_data[FS_W-1:0];
					default: ;
				endcase
			end

			if (is_load) begin
				if (lc_e == '0) begin
					min_q <= sample;
					max_q <= sample;
				end else begin
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
				end
				load_cnt_q <= lc_inc;
				complete_q <= load_done;
				// new frame or frame just closed: readout starts at pixel 0
				if (complete_q || load_done) begin
					rd_cnt_q <= '0;
					col_q    <= '0;
					row_q    <= '0;
					base_q   <= total_q - w_ext;
				end
			end else if (rd_en) begin
				rd_cnt_q <= rc_n;
				col_q    <= col_n;
				row_q    <= row_n;
				base_q   <= base_n;
			end

			// coordinates after a config write: col = rc % w, row = rc / w
			if (state_q == ST_CDIV && div_done) begin
				col_q  <= DIM_W'(div_rem);
				row_q  <= DIM_W'(div_quo);
				base_q <= total_q - w_ext - rd_cnt_q + CNT_W'(div_rem);
			end

			// a new result replaces the one leaving in the same cycle
			if (state_q == ST_OUT && out_free) begin
				pix_valid_q <= 1'b1;
			end else if (pix_valid_q && !pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && is_fetch) begin
			if (complete_q) begin
				pend_col_q  <= col_e[IDX_W-1:0];
				pend_row_q  <= row_e[IDX_W-1:0];
				pend_last_q <= rc_e == total_q - 1'b1;
				pend_rdy_q  <= 1'b1;
			end else begin
				pend_gray_q <= '0;
				pend_col_q  <= '0;
				pend_row_q  <= '0;
				pend_last_q <= 1'b0;
				pend_rdy_q  <= 1'b0;
			end
		end
		if (state_q == ST_READ) begin
			mag_q <= diff_mode_q ? abs_v : pos_d;
			den_q <= diff_mode_q ? fs_den : span_den;
		end
		if (state_q == ST_PRE && sat) begin
			pend_gray_q <= GRAY_MAX;
		end
		if (state_q == ST_GDIV && div_done) begin
			pend_gray_q <= div_quo[GRAY_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			gray_q    <= pend_gray_q;
			column_q  <= pend_col_q;
			out_row_q <= pend_row_q;
			last_q    <= pend_last_q;
			rdy_q     <= pend_rdy_q;
		end
	end

	assign pix_valid  = pix_valid_q;
	assign gray       = gray_q;
	assign column     = column_q;
	assign out_row    = out_row_q;
	assign last_pixel = last_q;
	assign ready_res  = rdy_q;

	// ---------------------------------------------------------------- assertions
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= max_q)
		else $error("running minimum above running maximum");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !ready_res) |->
		(gray == '0 && column == '0 && out_row == '0 && !last_pixel))
		else $error("not-ready pixel carries nonzero fields");

	a_coord_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && rd_cnt_q < total_q) |->
		(col_q < w_eff && (base_q + CNT_W'(col_q)) < total_q))
		else $error("readout coordinates outside the frame");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |=> !div_done)
		else $error("divider finished right after start");

endmodule

`default_nettype wire

FILE: sv/fmgn_store.sv
// Frame sample memory: one write port, one read port, registered read data.
// Depends on fmgn_pkg for the sample width.
`default_nettype none

module fmgn_store import fmgn_pkg::*; #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire logic [SAMPLE_W-1:0] wr_data,
	input  wire logic                rd_en,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output logic      [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fmgn_div.sv
// Restoring divider, one quotient bit per cycle.
// Short run gives GRAY_W quotient bits, long run gives Q_W. Depends on fmgn_pkg.
`default_nettype none

module fmgn_div import fmgn_pkg::*; #(
	parameter int NUM_W = 25,
	parameter int Q_W   = 17
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo,
	output logic      [DEN_W-1:0] rem,
	output logic                  done
);

	localparam int DSH_W   = DEN_W + Q_W - 1;
	localparam int CMP_W   = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int STEP_W  = $clog2(Q_W + 1);

	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [Q_W-1:0]    quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic             ge;
	logic [CMP_W-1:0] diff;

	assign ge   = CMP_W'(rem_q) >= CMP_W'(dsh_q);
	assign diff = CMP_W'(rem_q) - CMP_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= ctl.wide ? STEP_W'(Q_W) : STEP_W'(GRAY_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num;
			dsh_q <= ctl.wide ? (DSH_W'(den) << (Q_W - 1)) : (DSH_W'(den) << (GRAY_W - 1));
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[NUM_W-1:0];
			end
			quo_q <= {quo_q[Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q[DEN_W-1:0];
	assign done = done_q;

endmodule

`default_nettype wire
